// ----- rtl/core/lmc_pkg.sv -----
// Package for the LRU memo cache: request codes, controller states,
// controller command bundle and IEEE double classification helpers.
// Depends on nothing; every other file of the block imports it.
package lmc_pkg;

  // Request codes carried on the cmd field.
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_FILL   = 1'b1;

  // Field widths fixed by the interface.
  localparam int unsigned WORD_W = 64;

  // IEEE double masks used by the energy comparison.
  localparam logic [WORD_W-1:0] MAG_MASK = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [WORD_W-1:0] EXP_INF  = 64'h7FF0_0000_0000_0000;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // take the request and register the match vector
    logic update;   // reorder the entries and load the result register
  } ctl_cmd_t;

  // True when the pattern is a NaN of either sign.
  function automatic logic is_nan(input logic [WORD_W-1:0] bits);
    return (bits & MAG_MASK) > EXP_INF;
  endfunction

  // True for positive or negative zero.
  function automatic logic is_zero(input logic [WORD_W-1:0] bits);
    return (bits & MAG_MASK) == '0;
  endfunction

endpackage

// ----- rtl/core/lmc_ctrl.sv -----
// Controller of the LRU memo cache: a two-state machine that sequences
// capture and update, and owns the result valid flag. Depends on lmc_pkg.
module lmc_ctrl
  import lmc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ctl_cmd_t cmd_o
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // State and result flag registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands. The update waits until the result register is
  // free or is being emptied in this same cycle.
  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.update  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd_o.capture = in_valid;
        if (in_valid) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!out_valid_r || out_ready) begin
          cmd_o.update = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The result flag is set by an update and cleared when the result is taken.
  always_comb begin
    if (cmd_o.update) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  // An accepted request is always followed by its update phase.
  a_accept_to_update: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_UPDATE)
    else $error("accepted request did not enter the update phase");

  // Every update leaves a result waiting.
  a_update_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.update |=> out_valid_r)
    else $error("update did not produce a result");

endmodule

// ----- rtl/core/lmc_datapath.sv -----
// Datapath of the LRU memo cache: entry registers in recency order, key
// compare, move-to-front and fill shifting, result register. Uses lmc_pkg.
module lmc_datapath
  import lmc_pkg::*;
#(
  parameter int unsigned ENTRIES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_cmd_t          cmd_i,
  input  logic              in_cmd,
  input  logic [WORD_W-1:0] in_material_id,
  input  logic [WORD_W-1:0] in_energy_bits,
  input  logic [WORD_W-1:0] in_pe_in,
  input  logic [WORD_W-1:0] in_cs_in,
  input  logic [WORD_W-1:0] in_rs_in,
  input  logic [WORD_W-1:0] in_pp_in,
  output logic              out_hit,
  output logic [WORD_W-1:0] out_pe_out,
  output logic [WORD_W-1:0] out_cs_out,
  output logic [WORD_W-1:0] out_rs_out,
  output logic [WORD_W-1:0] out_pp_out
);

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  // Entry storage, entry 0 is the most recently used.
  logic [WORD_W-1:0] key_id_r     [ENTRIES];
  logic [WORD_W-1:0] key_energy_r [ENTRIES];
  logic [WORD_W-1:0] value_pe_r   [ENTRIES];
  logic [WORD_W-1:0] value_cs_r   [ENTRIES];
  logic [WORD_W-1:0] value_rs_r   [ENTRIES];
  logic [WORD_W-1:0] value_pp_r   [ENTRIES];

  logic [CNT_W-1:0]  fill_count_r;

  // Captured request.
  logic              cmd_r;
  logic [WORD_W-1:0] id_r, energy_r, pe_r, cs_r, rs_r, pp_r;
  logic [ENTRIES-1:0] match_r;

  logic [ENTRIES-1:0] valid;
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] first_oh;
  logic [ENTRIES-1:0] shift_mask;
  logic               hit;
  logic               move;
  logic               fill;
  logic [WORD_W-1:0]  found_pe, found_cs, found_rs, found_pp;
  logic               in_nan, in_zero;

  logic              out_hit_r;
  logic [WORD_W-1:0] out_pe_r, out_cs_r, out_rs_r, out_pp_r;

  // Compare the incoming key against every valid entry in parallel.
  assign in_nan  = is_nan(in_energy_bits);
  assign in_zero = is_zero(in_energy_bits);

  for (genvar j = 0; j < ENTRIES; j++) begin : g_cmp
    assign valid[j] = CNT_W'(j) < fill_count_r;
    assign match[j] = valid[j] && (key_id_r[j] == in_material_id) &&
                      !in_nan && !is_nan(key_energy_r[j]) &&
                      ((in_zero && is_zero(key_energy_r[j])) ||
                       (key_energy_r[j] == in_energy_bits));
  end

  // Request capture registers.
  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      cmd_r    <= in_cmd;
      id_r     <= in_material_id;
      energy_r <= in_energy_bits;
      pe_r     <= in_pe_in;
      cs_r     <= in_cs_in;
      rs_r     <= in_rs_in;
      pp_r     <= in_pp_in;
      match_r  <= match;
    end
  end

  // First match and the range of entries in front of it, both from one
  // subtraction: the lowest set bit, and every bit up to and including it.
  assign first_oh   = match_r & ~(match_r - ENTRIES'(1));
  assign shift_mask = match_r ^ (match_r - ENTRIES'(1));
  assign hit        = (cmd_r == CMD_LOOKUP) && (match_r != '0);
  assign move       = hit && !match_r[0];
  assign fill       = cmd_r == CMD_FILL;

  // Payload of the first matching entry.
  always_comb begin
    found_pe = '0;
    found_cs = '0;
    found_rs = '0;
    found_pp = '0;
    for (int j = 0; j < ENTRIES; j++) begin
      found_pe = found_pe | ({WORD_W{first_oh[j]}} & value_pe_r[j]);
      found_cs = found_cs | ({WORD_W{first_oh[j]}} & value_cs_r[j]);
      found_rs = found_rs | ({WORD_W{first_oh[j]}} & value_rs_r[j]);
      found_pp = found_pp | ({WORD_W{first_oh[j]}} & value_pp_r[j]);
    end
  end

  // Entry update: a fill shifts everything back, a hit behind the front
  // shifts only the entries ahead of the matching one.
  always_ff @(posedge clk) begin
    if (cmd_i.update) begin
      for (int j = 1; j < ENTRIES; j++) begin
        if (fill || (move && shift_mask[j])) begin
          key_id_r[j]     <= key_id_r[j-1];
          key_energy_r[j] <= key_energy_r[j-1];
          value_pe_r[j]   <= value_pe_r[j-1];
          value_cs_r[j]   <= value_cs_r[j-1];
          value_rs_r[j]   <= value_rs_r[j-1];
          value_pp_r[j]   <= value_pp_r[j-1];
        end
      end
      if (fill) begin
        key_id_r[0]     <= id_r;
        key_energy_r[0] <= energy_r;
        value_pe_r[0]   <= pe_r;
        value_cs_r[0]   <= cs_r;
        value_rs_r[0]   <= rs_r;
        value_pp_r[0]   <= pp_r;
      end else if (move) begin
        key_id_r[0]     <= id_r;
        key_energy_r[0] <= energy_r;
        value_pe_r[0]   <= found_pe;
        value_cs_r[0]   <= found_cs;
        value_rs_r[0]   <= found_rs;
        value_pp_r[0]   <= found_pp;
      end
    end
  end

  // Count of valid entries, saturating at the capacity.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_count_r <= '0;
    end else if (cmd_i.update && fill && (fill_count_r != CNT_W'(ENTRIES))) begin
      fill_count_r <= fill_count_r + CNT_W'(1);
    end
  end

  // Result register: payload on a hit, zeros otherwise.
  always_ff @(posedge clk) begin
    if (cmd_i.update) begin
      out_hit_r <= hit;
      out_pe_r  <= hit ? found_pe : '0;
      out_cs_r  <= hit ? found_cs : '0;
      out_rs_r  <= hit ? found_rs : '0;
      out_pp_r  <= hit ? found_pp : '0;
    end
  end

  assign out_hit    = out_hit_r;
  assign out_pe_out = out_pe_r;
  assign out_cs_out = out_cs_r;
  assign out_rs_out = out_rs_r;
  assign out_pp_out = out_pp_r;

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count_r <= CNT_W'(ENTRIES))
    else $error("fill count beyond capacity");

  // A fill always answers with a miss.
  a_fill_misses: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.update && fill |=> !out_hit_r)
    else $error("fill reported a hit");

endmodule

// ----- rtl/core/lru_memo_cache.sv -----
// LRU memo cache, fully associative and kept in most-recently-used order.
//
// Input channel (in_valid / in_ready): one request per item. in_cmd selects
// a lookup of the key (in_material_id, in_energy_bits) or a fill that puts
// the key and the four payload words at the front, dropping the oldest entry
// when the cache holds ENTRIES entries. Energies compare as doubles: NaN
// never matches and the two zeros are equal.
// Result channel (out_valid / out_ready): one result per request, hit flag
// and payload on a hit, all zero on a miss or a fill.
//
// An accepted request goes to the capture registers; its result is shown
// from the result register once its update is done, and no new request is
// taken before that. The steps: the parallel key compare into the registered
// match vector, then the move-to-front or fill shift and the result load.
// While a result waits in the output register the next request is still
// accepted; its update then holds until the waiting result is taken.
// Synchronous reset empties the cache (fill count to zero) and drops any
// pending result; entry contents are not cleared.
// Depends on lmc_pkg, lmc_ctrl and lmc_datapath.
module lru_memo_cache
  import lmc_pkg::*;
#(
  parameter int unsigned ENTRIES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [WORD_W-1:0] in_material_id,
  input  logic [WORD_W-1:0] in_energy_bits,
  input  logic [WORD_W-1:0] in_pe_in,
  input  logic [WORD_W-1:0] in_cs_in,
  input  logic [WORD_W-1:0] in_rs_in,
  input  logic [WORD_W-1:0] in_pp_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_hit,
  output logic [WORD_W-1:0] out_pe_out,
  output logic [WORD_W-1:0] out_cs_out,
  output logic [WORD_W-1:0] out_rs_out,
  output logic [WORD_W-1:0] out_pp_out
);

  ctl_cmd_t ctl_cmd;

  // Sequencer.
  lmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd_o     (ctl_cmd)
  );

  // Entry store, compare and result register.
  lmc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_i          (ctl_cmd),
    .in_cmd         (in_cmd),
    .in_material_id (in_material_id),
    .in_energy_bits (in_energy_bits),
    .in_pe_in       (in_pe_in),
    .in_cs_in       (in_cs_in),
    .in_rs_in       (in_rs_in),
    .in_pp_in       (in_pp_in),
    .out_hit        (out_hit),
    .out_pe_out     (out_pe_out),
    .out_cs_out     (out_cs_out),
    .out_rs_out     (out_rs_out),
    .out_pp_out     (out_pp_out)
  );

endmodule
